// File: hw/rtl/cbpm_pkg.sv
// Package for the clock buffer pool manager: sizes, codes and command/status structs.
// Depends on nothing; used by every module of the block.
package cbpm_pkg;

    localparam int NUM_FRAMES = 32;
    localparam int FW         = $clog2(NUM_FRAMES);
    localparam int CW         = FW + 1;
    localparam logic [15:0] PIN_MAX = 16'hFFFF;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_ALLOC   = 3'd1;
    localparam logic [2:0] OP_UNPIN   = 3'd2;
    localparam logic [2:0] OP_FLUSH   = 3'd3;
    localparam logic [2:0] OP_DISPOSE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXCEEDED = 2'd1;
    localparam logic [1:0] ST_NOTPIN   = 2'd2;
    localparam logic [1:0] ST_PINNED   = 2'd3;

    typedef struct packed {
        logic [4:0]  frame;
        logic        hit;
        logic [1:0]  status;
        logic        wb;
        logic [15:0] wb_file;
        logic [31:0] wb_page;
        logic        fetch;
        logic        last;
    } result_t;

    // controller -> datapath
    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_LOAD   = 4'd1,  // latch input item
        CMD_SCLR   = 4'd2,  // start scan at frame 0
        CMD_SNEXT  = 4'd3,  // scan index + 1
        CMD_HIT    = 4'd4,  // ref=1, pin++ on match
        CMD_HADV   = 4'd5,  // advance clock hand
        CMD_REFCLR = 4'd6,  // clear ref at hand + 1, advance hand
        CMD_FILL   = 4'd7,  // load frame at hand + 1, advance hand
        CMD_UNPIN  = 4'd8,
        CMD_DCLR   = 4'd10, // clear dirty at scan
        CMD_CLRS   = 4'd11  // clear frame at scan
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       scan_end;   // scan index reached active count
        logic       scan_match; // valid, tags match at scan index (file only if flush)
        logic       scan_free;  // invalid or unpinned at scan index
        logic       scan_dirty;
        logic       scan_pinned;
        logic       h_valid;    // at hand + 1
        logic       h_pinned;
        logic       h_ref;
        logic       h_dirty;
    } status_t;

endpackage

// File: hw/rtl/clock_buffer_pool_manager.sv
// Top level of the clock buffer pool manager: ports, controller and datapath.
// Depends on cbpm_pkg, cbpm_ctrl, cbpm_datapath.
// Sequence: read/alloc first scan the active frames for a tag match; a miss adds a free-frame
// scan and a clock sweep; flush walks the active frames and stops at a pinned match.
// Throughput: one item at a time; the next is taken once the final result is registered.
// Reset (rst_n, async low): all frames invalid and cleared, hand = 31, frames_in_use = 32.
module clock_buffer_pool_manager
    import cbpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: operation[2:0], file_id[18:3], page_no[50:19], mark_dirty[51], zero pad
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: result_frame[4:0], was_hit[5], status[7:6], is_writeback[8],
    //        writeback_file[24:9], writeback_page[56:25], need_fetch[57], zero pad
    output logic [63:0] m_tdata,
    output logic        m_tlast
);
    cmd_t    cmd;
    status_t st;
    result_t res_in, res_out;
    logic    res_set, res_full, in_rdy;
    logic [FW-1:0] scan_idx, hand_nxt;
    logic [15:0] h_file, s_file;
    logic [31:0] h_page, s_page;

    // Result register acts as the output stage; controller waits while it is full and not being taken.
    assign s_tready = in_rdy;
    assign m_tvalid = res_full;
    assign m_tlast  = res_out.last;
    assign m_tdata  = {6'd0, res_out.fetch, res_out.wb_page, res_out.wb_file,
                       res_out.wb, res_out.status, res_out.hit, res_out.frame};

    cbpm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_op(s_tdata[2:0]), .in_file(s_tdata[18:3]), .in_page(s_tdata[50:19]),
        .in_md(s_tdata[51]), .cmd(cmd), .res_set(res_set), .res_in(res_in),
        .res_take(m_tready), .res_full(res_full), .res_out(res_out), .st(st),
        .scan_idx(scan_idx), .hand_nxt(hand_nxt), .h_file(h_file), .h_page(h_page),
        .s_file(s_file), .s_page(s_page)
    );

    cbpm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && in_rdy), .in_rdy(in_rdy),
        .st(st), .scan_idx(scan_idx), .hand_nxt(hand_nxt),
        .h_file(h_file), .h_page(h_page),
        .s_page_file(s_file), .s_page(s_page), .res_full(res_full & ~m_tready),
        .cmd(cmd), .res_set(res_set), .res_in(res_in)
    );
endmodule

// File: hw/rtl/cbpm_datapath.sv
// Datapath: frame table registers, scan index, clock hand, item latch, result register.
// Depends on cbpm_pkg.
module cbpm_datapath
    import cbpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic [2:0]  in_op,
    input  logic [15:0] in_file,
    input  logic [31:0] in_page,
    input  logic        in_md,
    input  cmd_t        cmd,
    input  logic        res_set,
    input  result_t     res_in,
    input  logic        res_take,
    output logic        res_full,
    output result_t     res_out,
    output status_t     st,
    output logic [FW-1:0] scan_idx,
    output logic [FW-1:0] hand_nxt,
    output logic [15:0] h_file,
    output logic [31:0] h_page,
    output logic [15:0] s_file,
    output logic [31:0] s_page
);
    logic [NUM_FRAMES-1:0] valid_reg, ref_reg, dirty_reg;
    logic [15:0] file_reg [NUM_FRAMES];
    logic [31:0] page_reg [NUM_FRAMES];
    logic [15:0] pin_reg  [NUM_FRAMES];
    logic [FW-1:0] hand_reg;
    logic [CW-1:0] scan_reg;
    logic [5:0]  fiu_reg;
    logic [2:0]  op_reg;
    logic [15:0] f_reg;
    logic [31:0] p_reg;
    logic        md_reg, full_reg;
    result_t     res_reg;
    logic [CW-1:0] n;
    logic [FW-1:0] si;
    logic [CW-1:0] hp1;

    always_comb
    begin
        if (fiu_reg == 6'd0) n = CW'(1);
        else if ({1'b0, fiu_reg} > 7'(NUM_FRAMES)) n = CW'(NUM_FRAMES);
        else n = CW'(fiu_reg);
        hp1 = {1'b0, hand_reg} + CW'(1);
        hand_nxt = (hp1 >= n) ? '0 : hp1[FW-1:0];
        si = scan_reg[FW-1:0];
    end

    assign scan_idx = si;
    assign h_file   = file_reg[hand_nxt];
    assign h_page   = page_reg[hand_nxt];
    assign s_file   = file_reg[si];
    assign s_page   = page_reg[si];
    assign res_out  = res_reg;
    assign res_full = full_reg;

    always_comb
    begin
        st.op          = op_reg;
        st.scan_end    = (scan_reg >= n);
        st.scan_match  = valid_reg[si] && file_reg[si] == f_reg &&
                         (op_reg == OP_FLUSH || page_reg[si] == p_reg);
        st.scan_free   = !valid_reg[si] || pin_reg[si] == 16'd0;
        st.scan_dirty  = dirty_reg[si];
        st.scan_pinned = pin_reg[si] != 16'd0;
        st.h_valid     = valid_reg[hand_nxt];
        st.h_pinned    = pin_reg[hand_nxt] != 16'd0;
        st.h_ref       = ref_reg[hand_nxt];
        st.h_dirty     = dirty_reg[hand_nxt];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ref_reg   <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                file_reg[i] <= '0;
                page_reg[i] <= '0;
                pin_reg[i]  <= '0;
            end
            hand_reg  <= FW'(NUM_FRAMES - 1);
            fiu_reg   <= 6'd32;
            full_reg  <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            if (cfg_we) fiu_reg <= cfg_data;
            if (res_set) full_reg <= 1'b1;
            else if (res_take) full_reg <= 1'b0;
            unique case (cmd)
                CMD_LOAD:   ;
                CMD_SCLR:   scan_reg <= '0;
                CMD_SNEXT:  scan_reg <= scan_reg + CW'(1);
                CMD_HIT:
                begin
                    ref_reg[si] <= 1'b1;
                    if (pin_reg[si] != PIN_MAX) pin_reg[si] <= pin_reg[si] + 16'd1;
                end
                CMD_HADV:   hand_reg <= hand_nxt;
                CMD_REFCLR:
                begin
                    ref_reg[hand_nxt] <= 1'b0;
                    hand_reg <= hand_nxt;
                end
                CMD_FILL:
                begin
                    valid_reg[hand_nxt] <= 1'b1;
                    file_reg[hand_nxt]  <= f_reg;
                    page_reg[hand_nxt]  <= p_reg;
                    pin_reg[hand_nxt]   <= 16'd1;
                    ref_reg[hand_nxt]   <= 1'b1;
                    dirty_reg[hand_nxt] <= 1'b0;
                    hand_reg <= hand_nxt;
                end
                CMD_UNPIN:
                begin
                    if (md_reg) dirty_reg[si] <= 1'b1;
                    pin_reg[si] <= pin_reg[si] - 16'd1;
                end
                CMD_DCLR:   dirty_reg[si] <= 1'b0;
                CMD_CLRS:
                begin
                    valid_reg[si] <= 1'b0;
                    file_reg[si]  <= '0;
                    page_reg[si]  <= '0;
                    pin_reg[si]   <= '0;
                    ref_reg[si]   <= 1'b0;
                    dirty_reg[si] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            op_reg <= in_op;
            f_reg  <= in_file;
            p_reg  <= in_page;
            md_reg <= in_md;
        end
        if (res_set) res_reg <= res_in;
    end
endmodule

// File: hw/rtl/cbpm_ctrl.sv
// Controller state machine: sequences lookup, clock sweep, flush walk and result emission.
// Depends on cbpm_pkg; drives cbpm_datapath through cmd_t and reads status_t.
module cbpm_ctrl
    import cbpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    output logic        in_rdy,
    input  status_t     st,
    input  logic [FW-1:0] scan_idx,
    input  logic [FW-1:0] hand_nxt,
    input  logic [15:0] h_file,
    input  logic [31:0] h_page,
    input  logic [15:0] s_page_file,
    input  logic [31:0] s_page,
    input  logic        res_full,
    output cmd_t        cmd,
    output logic        res_set,
    output result_t     res_in
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIND  = 8'b0000_0010, // tag lookup over frames
        S_ANY   = 8'b0000_0100, // any unpinned/invalid frame
        S_SWEEP = 8'b0000_1000,
        S_FILL  = 8'b0001_0000,
        S_FLUSH = 8'b0010_0000,
        S_FPIN  = 8'b0100_0000, // flush: pin check on a match, after any dirty report
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_rdy = (state_reg == S_IDLE);

    function automatic result_t mk(input logic [4:0] fr, input logic h,
                                   input logic [1:0] s, input logic fe);
        result_t r;
        r = '0;
        r.frame = fr; r.hit = h; r.status = s; r.fetch = fe; r.last = 1'b1;
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cmd     = CMD_NONE;
        res_set = 1'b0;
        res_in  = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_DONE;
                end
            S_DONE:
            begin
                // after load: start scan, or answer an unknown op with an OK result
                cmd = CMD_SCLR;
                if (st.op == OP_FLUSH) state_next = S_FLUSH;
                else if (st.op <= OP_DISPOSE) state_next = S_FIND;
                else if (!res_full)
                begin
                    res_set = 1'b1;
                    res_in = mk(5'd0, 1'b0, ST_OK, 1'b0);
                    state_next = S_IDLE;
                    cmd = CMD_NONE;
                end
                else cmd = CMD_NONE;
            end
            S_FIND:
                if (st.scan_end)
                begin
                    if (st.op == OP_READ || st.op == OP_ALLOC)
                    begin
                        cmd = CMD_SCLR;
                        state_next = S_ANY;
                    end
                    else if (!res_full)
                    begin
                        res_set = 1'b1;
                        res_in = mk(5'd0, 1'b0, ST_OK, 1'b0);
                        state_next = S_IDLE;
                    end
                end
                else if (!st.scan_match) cmd = CMD_SNEXT;
                else if (!res_full)
                begin
                    state_next = S_IDLE;
                    res_set = 1'b1;
                    unique case (st.op)
                        OP_READ, OP_ALLOC:
                        begin
                            cmd = CMD_HIT;
                            res_in = mk(5'(scan_idx), 1'b1, ST_OK, 1'b0);
                        end
                        OP_UNPIN:
                            if (!st.scan_pinned)
                                res_in = mk(5'(scan_idx), 1'b1, ST_NOTPIN, 1'b0);
                            else
                            begin
                                cmd = CMD_UNPIN;
                                res_in = mk(5'(scan_idx), 1'b1, ST_OK, 1'b0);
                            end
                        default:
                            if (st.scan_pinned)
                                res_in = mk(5'(scan_idx), 1'b1, ST_PINNED, 1'b0);
                            else
                            begin
                                cmd = CMD_CLRS;
                                res_in = mk(5'(scan_idx), 1'b1, ST_OK, 1'b0);
                            end
                    endcase
                end
            S_ANY:
                if (st.scan_end)
                begin
                    if (!res_full)
                    begin
                        res_set = 1'b1;
                        res_in = mk(5'd0, 1'b0, ST_EXCEEDED, 1'b0);
                        state_next = S_IDLE;
                    end
                end
                else if (st.scan_free) state_next = S_SWEEP;
                else cmd = CMD_SNEXT;
            S_SWEEP:
                // a free frame exists, so this terminates within 2 passes
                if (!st.h_valid) state_next = S_FILL;
                else if (st.h_pinned) cmd = CMD_HADV;
                else if (st.h_ref) cmd = CMD_REFCLR;
                else if (st.h_dirty)
                begin
                    if (!res_full)
                    begin
                        res_set = 1'b1;
                        res_in = '0;
                        res_in.frame = 5'(hand_nxt);
                        res_in.wb = 1'b1;
                        res_in.wb_file = h_file;
                        res_in.wb_page = h_page;
                        state_next = S_FILL;
                    end
                end
                else state_next = S_FILL;
            S_FILL:
                if (!res_full)
                begin
                    cmd = CMD_FILL;
                    res_set = 1'b1;
                    res_in = mk(5'(hand_nxt), 1'b0, ST_OK, st.op == OP_READ);
                    state_next = S_IDLE;
                end
            S_FLUSH:
                if (st.scan_end)
                begin
                    if (!res_full)
                    begin
                        res_set = 1'b1;
                        res_in = mk(5'd0, 1'b0, ST_OK, 1'b0);
                        state_next = S_IDLE;
                    end
                end
                else if (!st.scan_match) cmd = CMD_SNEXT;
                else if (st.scan_dirty)
                begin
                    if (!res_full)
                    begin
                        cmd = CMD_DCLR;
                        res_set = 1'b1;
                        res_in = '0;
                        res_in.frame = 5'(scan_idx);
                        res_in.wb = 1'b1;
                        res_in.wb_file = s_page_file;
                        res_in.wb_page = s_page;
                        state_next = S_FPIN;
                    end
                end
                else state_next = S_FPIN;
            S_FPIN:
                if (st.scan_pinned)
                begin
                    if (!res_full)
                    begin
                        res_set = 1'b1;
                        res_in = mk(5'(scan_idx), 1'b1, ST_PINNED, 1'b0);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd = CMD_CLRS;
                    state_next = S_FLUSH;
                end
            default: state_next = S_IDLE;
        endcase
    end

    // CLRS leaves scan index in place; next S_FLUSH cycle sees invalid frame and steps on.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// File: hw/rtl/cbpm_checker.sv
// Port-level checker for the clock buffer pool manager, with its bind.
// Depends on cbpm_pkg and the top-level ports.
module cbpm_checker
    import cbpm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> !m_tlast)
        else $error("writeback marked last");
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");
    a_fetch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[57] |-> m_tdata[7:6] == ST_OK && !m_tdata[5])
        else $error("fetch with bad status");
endmodule

bind clock_buffer_pool_manager cbpm_checker u_chk (.*);

// File: sim/clock_buffer_pool_manager_tb.sv
// Testbench for clock_buffer_pool_manager: directed and random page operations,
// checked against a behavioral model of the clock frame table. Needs cbpm_pkg and the RTL.
`timescale 1ns / 1ps

module clock_buffer_pool_manager_tb;
    import cbpm_pkg::*;

    typedef struct {
        logic [4:0]  frame;
        logic        hit;
        logic [1:0]  status;
        logic        wb;
        logic [15:0] wb_file;
        logic [31:0] wb_page;
        logic        fetch;
        logic        last;
    } pool_result_t;

    // Frame table model plus the queue of results it predicts.
    class pool_scoreboard;
        bit          valid [NUM_FRAMES];
        bit [15:0]   file_tag [NUM_FRAMES];
        bit [31:0]   page_tag [NUM_FRAMES];
        bit [15:0]   pins [NUM_FRAMES];
        bit          refb [NUM_FRAMES];
        bit          dirty [NUM_FRAMES];
        bit [4:0]    hand;
        bit [5:0]    frames_in_use;
        pool_result_t pending[$];
        int          mismatches;

        function void reset_state();
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid[i] = 0; file_tag[i] = 0; page_tag[i] = 0;
                pins[i] = 0; refb[i] = 0; dirty[i] = 0;
            end
            hand = 5'd31;
            frames_in_use = 6'd32;
        endfunction

        function int active();
            int n;
            n = frames_in_use;
            if (n == 0) n = 1;
            if (n > NUM_FRAMES) n = NUM_FRAMES;
            return n;
        endfunction

        function void push(logic [4:0] fr, bit h, logic [1:0] st, bit w,
                           logic [15:0] wf, logic [31:0] wp, bit fe, bit l);
            pool_result_t r;
            r.frame = fr; r.hit = h; r.status = st; r.wb = w;
            r.wb_file = wf; r.wb_page = wp; r.fetch = fe; r.last = l;
            pending.push_back(r);
        endfunction

        function int lookup(int n, bit [15:0] f, bit [31:0] p);
            for (int i = 0; i < n; i++)
                if (valid[i] && file_tag[i] == f && page_tag[i] == p) return i;
            return -1;
        endfunction

        function void wipe(int i);
            valid[i] = 0; file_tag[i] = 0; page_tag[i] = 0;
            pins[i] = 0; refb[i] = 0; dirty[i] = 0;
        endfunction

        // Second-chance sweep; -1 when every managed frame is pinned.
        function int pick_victim(int n);
            bit any;
            int h;
            any = 0;
            for (int i = 0; i < n; i++)
                if (!valid[i] || pins[i] == 0) any = 1;
            if (!any) return -1;
            for (int s = 0; s <= 2 * n; s++)
            begin
                h = hand + 1;
                if (h >= n) h = 0;
                hand = 5'(h);
                if (!valid[h]) return h;
                if (pins[h] != 0) continue;
                if (refb[h]) begin refb[h] = 0; continue; end
                return h;
            end
            return -1;
        endfunction

        function void note_item(logic [2:0] op, logic [15:0] f, logic [31:0] p, logic md);
            int n, fr;
            n = active();
            case (op)
                OP_READ, OP_ALLOC:
                begin
                    fr = lookup(n, f, p);
                    if (fr >= 0)
                    begin
                        refb[fr] = 1;
                        if (pins[fr] != PIN_MAX) pins[fr]++;
                        push(5'(fr), 1, ST_OK, 0, 0, 0, 0, 1);
                    end
                    else
                    begin
                        fr = pick_victim(n);
                        if (fr < 0)
                            push(0, 0, ST_EXCEEDED, 0, 0, 0, 0, 1);
                        else
                        begin
                            if (valid[fr] && dirty[fr])
                                push(5'(fr), 0, ST_OK, 1, file_tag[fr], page_tag[fr], 0, 0);
                            valid[fr] = 1; file_tag[fr] = f; page_tag[fr] = p;
                            pins[fr] = 1; refb[fr] = 1; dirty[fr] = 0;
                            push(5'(fr), 0, ST_OK, 0, 0, 0, op == OP_READ, 1);
                        end
                    end
                end
                OP_UNPIN:
                begin
                    fr = lookup(n, f, p);
                    if (fr < 0) push(0, 0, ST_OK, 0, 0, 0, 0, 1);
                    else if (pins[fr] == 0) push(5'(fr), 1, ST_NOTPIN, 0, 0, 0, 0, 1);
                    else
                    begin
                        if (md) dirty[fr] = 1;
                        pins[fr]--;
                        push(5'(fr), 1, ST_OK, 0, 0, 0, 0, 1);
                    end
                end
                OP_FLUSH:
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (!valid[i] || file_tag[i] != f) continue;
                        if (dirty[i])
                        begin
                            push(5'(i), 0, ST_OK, 1, file_tag[i], page_tag[i], 0, 0);
                            dirty[i] = 0;
                        end
                        if (pins[i] != 0)
                        begin
                            push(5'(i), 1, ST_PINNED, 0, 0, 0, 0, 1);
                            return;
                        end
                        wipe(i);
                    end
                    push(0, 0, ST_OK, 0, 0, 0, 0, 1);
                end
                OP_DISPOSE:
                begin
                    fr = lookup(n, f, p);
                    if (fr < 0) push(0, 0, ST_OK, 0, 0, 0, 0, 1);
                    else if (pins[fr] != 0) push(5'(fr), 1, ST_PINNED, 0, 0, 0, 0, 1);
                    else
                    begin
                        wipe(fr);
                        push(5'(fr), 1, ST_OK, 0, 0, 0, 0, 1);
                    end
                end
                default: push(0, 0, ST_OK, 0, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_result(logic [63:0] d, logic l);
            pool_result_t e;
            bit bad;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h last %b", d, l);
                return;
            end
            e = pending.pop_front();
            bad = d[4:0] !== e.frame || d[5] !== e.hit || d[7:6] !== e.status ||
                  d[8] !== e.wb || d[24:9] !== e.wb_file || d[56:25] !== e.wb_page ||
                  d[57] !== e.fetch || l !== e.last || d[63:58] !== 6'd0;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp frame %0d hit %b st %0d wb %b %h/%h fetch %b last %b",
                             e.frame, e.hit, e.status, e.wb, e.wb_file, e.wb_page,
                             e.fetch, e.last);
                    $display("          got frame %0d hit %b st %0d wb %b %h/%h fetch %b last %b",
                             d[4:0], d[5], d[7:6], d[8], d[24:9], d[56:25], d[57], l);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 4 * NUM_FRAMES + 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    pool_scoreboard board;
    int  cycles;
    bit  stall_free;   // quiet stretch: no idling on either side

    clock_buffer_pool_manager dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Sample results at the rising edge; the model is updated at acceptance too.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
        if (rst_n && s_tvalid && s_tready)
            board.note_item(s_tdata[2:0], s_tdata[18:3], s_tdata[50:19], s_tdata[51]);
    end

    // Receiver backpressure, about 15 percent, changed on the falling edge.
    always @(negedge clk)
        m_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 15);

    always @(posedge clk)
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end

    // Offer one item and hold it until accepted; random idle gaps before it.
    // Blocking writes at the falling edge, so back-to-back items never collide.
    task automatic send_item(logic [2:0] op, logic [15:0] f, logic [31:0] p, logic md);
        while (!stall_free && $urandom_range(99) < 15) @(negedge clk);
        s_tdata  = {4'd0, md, p, f, op};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Register write only while idle.
    task automatic set_frames(logic [5:0] v);
        drain();
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        board.frames_in_use = v;
    endtask

    // Random item biased toward a small set of pages so that hits, pins and sweeps occur.
    task automatic random_item();
        logic [2:0]  op;
        logic [15:0] f;
        logic [31:0] p;
        int          r;
        r = $urandom_range(99);
        if (r < 38) op = OP_READ;
        else if (r < 50) op = OP_ALLOC;
        else if (r < 82) op = OP_UNPIN;
        else if (r < 88) op = OP_FLUSH;
        else if (r < 97) op = OP_DISPOSE;
        else op = 3'($urandom_range(7, 5));
        if ($urandom_range(9) == 0) f = 16'($urandom);
        else f = 16'($urandom_range(3, 1));
        if ($urandom_range(9) == 0) p = $urandom;
        else p = $urandom_range(11);
        send_item(op, f, p, 1'($urandom_range(1)));
    endtask

    initial
    begin
        board = new();
        board.reset_state();
        cycles     = 0;
        stall_free = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = 6'd0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: small pool so full-pin and dirty writeback appear quickly.
        set_frames(6'd2);
        send_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);  // miss, fetch
        send_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);  // hit, pin 2
        send_item(OP_ALLOC, 16'h0000, 32'h0, 1'b0);          // file tag zero
        send_item(OP_ALLOC, 16'h0000, 32'h0, 1'b0);          // alloc of resident page
        send_item(OP_READ, 16'h1234, 32'h5, 1'b0);           // all pinned
        send_item(OP_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);  // pin count already zero
        send_item(OP_UNPIN, 16'h7777, 32'h1, 1'b1);          // absent page
        send_item(OP_READ, 16'h0001, 32'h8000_0000, 1'b0);   // dirty victim writeback
        send_item(OP_DISPOSE, 16'h0001, 32'h8000_0000, 1'b0); // pinned
        send_item(OP_UNPIN, 16'h0001, 32'h8000_0000, 1'b1);
        send_item(OP_DISPOSE, 16'h0001, 32'h8000_0000, 1'b0); // cleared
        send_item(OP_DISPOSE, 16'h0002, 32'h3, 1'b0);         // absent
        send_item(OP_UNPIN, 16'h0000, 32'h0, 1'b1);
        send_item(OP_UNPIN, 16'h0000, 32'h0, 1'b1);
        send_item(OP_FLUSH, 16'h0000, 32'hDEAD_BEEF, 1'b0);   // writeback then clear
        send_item(OP_READ, 16'h00AA, 32'h1, 1'b0);
        send_item(OP_UNPIN, 16'h00AA, 32'h1, 1'b1);
        send_item(OP_READ, 16'h00AA, 32'h1, 1'b0);
        send_item(OP_FLUSH, 16'h00AA, 32'h0, 1'b0);           // writeback then pinned stop
        send_item(3'd5, 16'h1, 32'h1, 1'b1);
        send_item(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);

        // Zero count clamps to one; a shrink leaves the hand past the count.
        set_frames(6'd0);
        send_item(OP_READ, 16'h00AA, 32'h1, 1'b0);
        send_item(OP_ALLOC, 16'h0003, 32'h9, 1'b0);

        // Random phases across pool sizes, with extremes and a quiet stretch.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_frames(6'd32);
                1: set_frames(6'd63);
                2: set_frames(6'd1);
                3: set_frames(6'd4);
                4: set_frames(6'd3);
                default: set_frames(6'($urandom_range(31, 2)));
            endcase
            stall_free = (ph == 5);
            for (int i = 0; i < 42; i++) random_item();
            if (ph == 3)
            begin
                // Hold off new items until every predicted result is out.
                while (board.pending.size() != 0) @(negedge clk);
            end
        end
        stall_free = 0;

        drain();
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
